// ===== design/crav_pkg.sv =====
// Shared types and constants for the constraint run averager.
package crav_pkg;

   localparam int FRAME_INDEX_BITS = 16;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [39:0] WSUM_MAX = {40{1'b1}};
   localparam logic signed [47:0] QSUM_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] QSUM_MIN = {1'b1, {47{1'b0}}};
   localparam logic signed [63:0] TSUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] TSUM_MIN = {1'b1, {63{1'b0}}};
   localparam logic [47:0] MAG_LIMIT = 48'h0000_4000_0000;
   localparam int DIV_DVD_BITS = 64;
   localparam int DIV_DVS_BITS = 40;

   typedef struct packed {
      logic [16:0]        constraint_value;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic               last_frame;
   } req_type;

   typedef struct packed {
      logic [15:0]        start_frame;
      logic [15:0]        end_frame;
      logic signed [31:0] avg_trans_x;
      logic signed [31:0] avg_trans_y;
      logic signed [31:0] avg_trans_z;
      logic signed [15:0] avg_quat_w;
      logic signed [15:0] avg_quat_x;
      logic signed [15:0] avg_quat_y;
      logic signed [15:0] avg_quat_z;
   } rsp_type;

endpackage

// ===== design/constraint_run_averager_top.sv =====
// Constraint run averager: sequencer, accumulators and closing arithmetic.
// A frame that only accumulates steps through the weight, translation, dot product and
// quaternion states; closing a run adds three divides, the magnitude, shift, square and root
// steps, up to four divides and the write, most of the busy time going to the shared divider.
// Throughput: one frame at a time; a result waits in the output register.
// Reset (synchronous, active high) closes any run and zeroes the frame counter.
module constraint_run_averager_top
   import crav_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_WSUM, S_TMUL, S_TADD, S_DMUL, S_DADD, S_QMUL, S_QADD,
      S_DSTART, S_DWAIT, S_MAG, S_SHIFT, S_SMUL, S_SADD, S_ROOT, S_RWAIT,
      S_QSTART, S_QWAIT, S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic                        run_open_ff, run_open_in;
   logic [FRAME_INDEX_BITS-1:0] frame_ff, frame_in;
   logic [15:0]                 start_ff, start_in;
   logic [15:0]                 end_ff, end_in;
   logic                        emit_ff, emit_in;
   logic [39:0]                 wsum_ff, wsum_in;
   logic signed [63:0]          tsum_ff [3];
   logic signed [63:0]          tsum_in [3];
   logic signed [47:0]          qsum_ff [4];
   logic signed [47:0]          qsum_in [4];
   req_type                     in_ff, in_in;
   logic [16:0]                 w_ff, w_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic signed [63:0]          prod_ff, prod_in;
   logic signed [65:0]          dot_ff, dot_in;
   logic [47:0]                 mag_ff [4];
   logic [47:0]                 mag_in [4];
   logic [61:0]                 sq_ff, sq_in;
   logic [31:0]                 norm_ff, norm_in;
   logic signed [31:0]          avgt_ff [3];
   logic signed [31:0]          avgt_in [3];
   logic signed [15:0]          avgq_ff [4];
   logic signed [15:0]          avgq_in [4];
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // shared divider and root unit hookup
   logic                    div_start;
   logic [DIV_DVD_BITS-1:0] div_dvd;
   logic [DIV_DVS_BITS-1:0] div_dvs;
   logic                    div_done;
   logic [DIV_DVD_BITS-1:0] div_quo;
   logic                    sqrt_start;
   logic                    sqrt_done;
   logic [31:0]             sqrt_root;

   logic signed [31:0] tin [3];
   logic signed [15:0] qin [4];
   logic signed [17:0] wext;
   logic signed [49:0] mul_t;
   logic signed [63:0] mul_d;
   logic signed [33:0] mul_q;
   logic [59:0]        mul_s;
   logic signed [64:0] tsum_add;
   logic signed [48:0] qsum_add;
   logic signed [63:0] qterm;
   logic [40:0]        wsum_add;
   logic               accept, constrained, any_big;
   logic [FRAME_INDEX_BITS-1:0] prev_idx;

   assign tin[0] = in_ff.trans_x;
   assign tin[1] = in_ff.trans_y;
   assign tin[2] = in_ff.trans_z;
   assign qin[0] = in_ff.quat_w;
   assign qin[1] = in_ff.quat_x;
   assign qin[2] = in_ff.quat_y;
   assign qin[3] = in_ff.quat_z;
   assign wext   = {1'b0, w_ff};

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid & req_ready;
   assign constrained = (req_data.constraint_value < ONE_Q16);
   assign prev_idx    = frame_ff - 1'b1;

   // one multiply at a time, registered before it is summed
   assign mul_t = tin[cnt_ff] * wext;
   assign mul_d = qsum_ff[cnt_ff] * qin[cnt_ff];
   assign mul_q = qin[cnt_ff] * wext;
   assign mul_s = mag_ff[cnt_ff][29:0] * mag_ff[cnt_ff][29:0];

   assign qterm    = (dot_ff > 66'sd0) ? prod_ff : -prod_ff;
   assign tsum_add = 65'(tsum_ff[cnt_ff[1:0]]) + 65'(prod_ff);
   assign qsum_add = 49'(qsum_ff[cnt_ff]) + 49'(qterm);
   assign wsum_add = {1'b0, wsum_ff} + 41'(w_ff);
   assign any_big  = (mag_ff[0] >= MAG_LIMIT) || (mag_ff[1] >= MAG_LIMIT) ||
                     (mag_ff[2] >= MAG_LIMIT) || (mag_ff[3] >= MAG_LIMIT);

   always_comb begin
      state_in    = state_ff;
      run_open_in = run_open_ff;
      frame_in    = frame_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      emit_in     = emit_ff;
      wsum_in     = wsum_ff;
      tsum_in     = tsum_ff;
      qsum_in     = qsum_ff;
      in_in       = in_ff;
      w_in        = w_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      dot_in      = dot_ff;
      mag_in      = mag_ff;
      sq_in       = sq_ff;
      norm_in     = norm_ff;
      avgt_in     = avgt_ff;
      avgq_in     = avgq_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      div_start   = 1'b0;
      div_dvd     = '0;
      div_dvs     = wsum_ff;
      sqrt_start  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               in_in  = req_data;
               w_in   = ONE_Q16 - req_data.constraint_value;
               cnt_in = '0;
               if (constrained) begin
                  // open a run and clear the sums on its first frame
                  if (!run_open_ff) begin
                     start_in = 16'(frame_ff);
                     wsum_in  = '0;
                     for (int i = 0; i < 3; i++) tsum_in[i] = '0;
                     for (int i = 0; i < 4; i++) qsum_in[i] = '0;
                  end
                  run_open_in = ~req_data.last_frame;
                  emit_in     = req_data.last_frame;
                  end_in      = 16'(frame_ff);
                  state_in    = S_WSUM;
               end else begin
                  run_open_in = 1'b0;
                  emit_in     = run_open_ff;
                  end_in      = 16'(prev_idx);
                  state_in    = run_open_ff ? S_DSTART : S_IDLE;
               end
               frame_in = req_data.last_frame ? '0 : frame_ff + 1'b1;
            end
         end
         S_WSUM: begin
            wsum_in  = wsum_add[40] ? WSUM_MAX : wsum_add[39:0];
            state_in = S_TMUL;
         end
         S_TMUL: begin
            prod_in  = 64'(mul_t);
            state_in = S_TADD;
         end
         S_TADD: begin
            if (tsum_add[64] != tsum_add[63])
               tsum_in[cnt_ff] = tsum_add[64] ? TSUM_MIN : TSUM_MAX;
            else
               tsum_in[cnt_ff] = tsum_add[63:0];
            if (cnt_ff == 2'd2) begin
               cnt_in   = '0;
               dot_in   = '0;
               state_in = S_DMUL;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_TMUL;
            end
         end
         S_DMUL: begin
            prod_in  = mul_d;
            state_in = S_DADD;
         end
         S_DADD: begin
            dot_in = dot_ff + 66'(prod_ff);
            cnt_in = cnt_ff + 2'd1;
            state_in = (cnt_ff == 2'd3) ? S_QMUL : S_DMUL;
         end
         S_QMUL: begin
            prod_in  = 64'(mul_q);
            state_in = S_QADD;
         end
         S_QADD: begin
            if (qsum_add[48] != qsum_add[47])
               qsum_in[cnt_ff] = qsum_add[48] ? QSUM_MIN : QSUM_MAX;
            else
               qsum_in[cnt_ff] = qsum_add[47:0];
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3)
               state_in = emit_ff ? S_DSTART : S_IDLE;
            else
               state_in = S_QMUL;
         end
         S_DSTART: begin
            // divide the magnitude, restore the sign afterwards
            div_start = 1'b1;
            div_dvd   = tsum_ff[cnt_ff][63] ? 64'(-tsum_ff[cnt_ff]) : 64'(tsum_ff[cnt_ff]);
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               if (wsum_ff == '0)
                  avgt_in[cnt_ff] = '0;
               else if (tsum_ff[cnt_ff][63])
                  avgt_in[cnt_ff] = (div_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                              : -32'(div_quo);
               else
                  avgt_in[cnt_ff] = (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                              : 32'(div_quo);
               if (cnt_ff == 2'd2) begin
                  cnt_in   = '0;
                  state_in = S_MAG;
               end else begin
                  cnt_in   = cnt_ff + 2'd1;
                  state_in = S_DSTART;
               end
            end
         end
         S_MAG: begin
            for (int i = 0; i < 4; i++)
               mag_in[i] = qsum_ff[i][47] ? 48'(-qsum_ff[i]) : 48'(qsum_ff[i]);
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // shift all magnitudes down together until each fits in 30 bits
            if (any_big) begin
               for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               cnt_in   = '0;
               sq_in    = '0;
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            prod_in  = 64'(mul_s);
            state_in = S_SADD;
         end
         S_SADD: begin
            sq_in  = sq_ff + prod_ff[61:0];
            cnt_in = cnt_ff + 2'd1;
            state_in = (cnt_ff == 2'd3) ? S_ROOT : S_SMUL;
         end
         S_ROOT: begin
            sqrt_start = 1'b1;
            state_in   = S_RWAIT;
         end
         S_RWAIT: begin
            if (sqrt_done) begin
               norm_in  = sqrt_root;
               cnt_in   = '0;
               state_in = S_QSTART;
            end
         end
         S_QSTART: begin
            if (norm_ff == '0) begin
               avgq_in[cnt_ff] = '0;
               cnt_in   = cnt_ff + 2'd1;
               state_in = (cnt_ff == 2'd3) ? S_WRITE : S_QSTART;
            end else begin
               // round to nearest: add half the length before dividing
               div_start = 1'b1;
               div_dvd   = {19'd0, mag_ff[cnt_ff][29:0], 15'd0} + {33'd0, norm_ff[31:1]};
               div_dvs   = {8'd0, norm_ff};
               state_in  = S_QWAIT;
            end
         end
         S_QWAIT: begin
            div_dvs = {8'd0, norm_ff};
            if (div_done) begin
               if (qsum_ff[cnt_ff][47])
                  avgq_in[cnt_ff] = (div_quo > 64'd32768) ? 16'sh8000 : -16'(div_quo);
               else
                  avgq_in[cnt_ff] = (div_quo > 64'd32767) ? 16'sh7FFF : 16'(div_quo);
               cnt_in   = cnt_ff + 2'd1;
               state_in = (cnt_ff == 2'd3) ? S_WRITE : S_QSTART;
            end
         end
         S_WRITE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.start_frame  = start_ff;
               rsp_in.end_frame    = end_ff;
               rsp_in.avg_trans_x  = avgt_ff[0];
               rsp_in.avg_trans_y  = avgt_ff[1];
               rsp_in.avg_trans_z  = avgt_ff[2];
               rsp_in.avg_quat_w   = avgq_ff[0];
               rsp_in.avg_quat_x   = avgq_ff[1];
               rsp_in.avg_quat_y   = avgq_ff[2];
               rsp_in.avg_quat_z   = avgq_ff[3];
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_open_ff  <= 1'b0;
         frame_ff     <= '0;
         start_ff     <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wsum_ff      <= '0;
         for (int i = 0; i < 3; i++) tsum_ff[i] <= '0;
         for (int i = 0; i < 4; i++) qsum_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         run_open_ff  <= run_open_in;
         frame_ff     <= frame_in;
         start_ff     <= start_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         wsum_ff      <= wsum_in;
         tsum_ff      <= tsum_in;
         qsum_ff      <= qsum_in;
      end
      end_ff  <= end_in;
      in_ff   <= in_in;
      w_ff    <= w_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      dot_ff  <= dot_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      norm_ff <= norm_in;
      avgt_ff <= avgt_in;
      avgq_ff <= avgq_in;
      rsp_ff  <= rsp_in;
   end

   crav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   crav_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/crav_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module crav_div
   import crav_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_DVD_BITS-1:0] dividend,
   input  logic [DIV_DVS_BITS-1:0] divisor,
   output logic                    done,
   output logic [DIV_DVD_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic [DIV_DVD_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DVS_BITS:0]   rem_ff, rem_in;
   logic [DIV_DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [DIV_DVS_BITS:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[DIV_DVS_BITS-1:0], quo_ff[DIV_DVD_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIV_DVD_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_DVD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_DVD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/crav_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module crav_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = {2'b00, radicand};
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== verif/tb_constraint_run_averager_top.sv =====
// Self-checking testbench for the constraint run averager top level.
module tb_constraint_run_averager_top;
   import crav_pkg::*;

   localparam int LIMIT_CYCLES = 5_000_000;
   localparam int RANDOM_ITEMS = 1050;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   constraint_run_averager_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: mirrors the block's run tracking and accumulators.
   logic               run_is_open;
   logic [15:0]        frame_idx;
   logic [15:0]        first_frame;
   logic [39:0]        wsum;
   logic signed [63:0] tsum [3];
   logic signed [47:0] qsum [4];

   rsp_type averages_due [$];
   int      fail_count = 0;
   int      runs_closed = 0;
   int      cycle_count = 0;
   logic    quiet_tail = 1'b0;
   logic    hold_long = 1'b0;

   function automatic longint sat_sum(longint a, longint b, longint lo, longint hi);
      if (b > 0 && a > hi - b) return hi;
      if (b < 0 && a < lo - b) return lo;
      return a + b;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void clear_sums();
      wsum = '0;
      for (int i = 0; i < 3; i++) tsum[i] = '0;
      for (int i = 0; i < 4; i++) qsum[i] = '0;
   endfunction

   function automatic void add_frame(req_type f);
      longint w, t, p;
      logic signed [15:0] q [4];
      logic signed [129:0] dot;
      q[0] = f.quat_w; q[1] = f.quat_x; q[2] = f.quat_y; q[3] = f.quat_z;
      w = 65536 - longint'(f.constraint_value);
      wsum = 40'(sat_sum(longint'({24'd0, wsum}), w, 0, (64'd1 << 40) - 1));
      t = longint'(f.trans_x) * w; tsum[0] = sat_sum(tsum[0], t, 64'h8000_0000_0000_0000,
         64'h7fff_ffff_ffff_ffff);
      t = longint'(f.trans_y) * w; tsum[1] = sat_sum(tsum[1], t, 64'h8000_0000_0000_0000,
         64'h7fff_ffff_ffff_ffff);
      t = longint'(f.trans_z) * w; tsum[2] = sat_sum(tsum[2], t, 64'h8000_0000_0000_0000,
         64'h7fff_ffff_ffff_ffff);
      dot = '0;
      for (int i = 0; i < 4; i++) dot += 130'(qsum[i]) * 130'(q[i]);
      for (int i = 0; i < 4; i++) begin
         p = longint'(q[i]) * w;
         if (!(dot > 0)) p = -p;
         qsum[i] = 48'(sat_sum(longint'(qsum[i]), p, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1));
      end
   endfunction

   function automatic rsp_type close_run(logic [15:0] end_idx);
      rsp_type r;
      longint a, s;
      longint unsigned m [4];
      longint unsigned mx, sq, len, v;
      int k;
      r = '0;
      r.start_frame = first_frame;
      r.end_frame = end_idx;
      for (int i = 0; i < 3; i++) begin
         a = 0;
         if (wsum != 0) begin
            a = tsum[i] / longint'({24'd0, wsum});
            if (a > 64'sd2147483647) a = 64'sd2147483647;
            if (a < -64'sd2147483648) a = -64'sd2147483648;
         end
         case (i)
            0: r.avg_trans_x = 32'(a);
            1: r.avg_trans_y = 32'(a);
            default: r.avg_trans_z = 32'(a);
         endcase
      end
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         s = qsum[i];
         m[i] = s < 0 ? longint'(-s) : longint'(s);
         if (m[i] > mx) mx = m[i];
      end
      k = 0;
      while ((mx >> k) >= (64'd1 << 30)) k++;
      sq = 0;
      for (int i = 0; i < 4; i++) begin
         m[i] >>= k;
         sq += m[i] * m[i];
      end
      len = root_floor(sq);
      for (int i = 0; i < 4; i++) begin
         logic signed [15:0] o;
         o = '0;
         if (len != 0) begin
            v = (m[i] * 32768 + len / 2) / len;
            if (qsum[i] < 0) o = 16'(-longint'(v > 32768 ? 32768 : v));
            else o = 16'(v > 32767 ? 32767 : v);
         end
         case (i)
            0: r.avg_quat_w = o;
            1: r.avg_quat_x = o;
            2: r.avg_quat_y = o;
            default: r.avg_quat_z = o;
         endcase
      end
      return r;
   endfunction

   // Advance the predictor by one accepted frame; queue an average when a run closes.
   function automatic void predict_frame(req_type f);
      logic constrained;
      constrained = f.constraint_value < ONE_Q16;
      if (constrained) begin
         if (!run_is_open) begin
            run_is_open = 1'b1;
            first_frame = frame_idx;
            clear_sums();
         end
         add_frame(f);
         if (f.last_frame) begin
            averages_due = {averages_due, close_run(frame_idx)};
            run_is_open = 1'b0;
         end
      end else if (run_is_open) begin
         averages_due = {averages_due, close_run(frame_idx - 16'd1)};
         run_is_open = 1'b0;
      end
      if (f.last_frame) begin
         frame_idx = '0;
         run_is_open = 1'b0;
      end else begin
         frame_idx = frame_idx + 16'd1;
      end
   endfunction

   // Compare each result transfer with the oldest queued average.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (averages_due.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            fail_count++;
         end else begin
            rsp_type e;
            e = averages_due.pop_front();
            runs_closed++;
            if (rsp_data.start_frame !== e.start_frame) begin
               $error("start_frame exp %0d got %0d", e.start_frame, rsp_data.start_frame);
               fail_count++;
            end
            if (rsp_data.end_frame !== e.end_frame) begin
               $error("end_frame exp %0d got %0d", e.end_frame, rsp_data.end_frame);
               fail_count++;
            end
            if (rsp_data.avg_trans_x !== e.avg_trans_x) begin
               $error("avg_trans_x exp %0d got %0d", e.avg_trans_x, rsp_data.avg_trans_x);
               fail_count++;
            end
            if (rsp_data.avg_trans_y !== e.avg_trans_y) begin
               $error("avg_trans_y exp %0d got %0d", e.avg_trans_y, rsp_data.avg_trans_y);
               fail_count++;
            end
            if (rsp_data.avg_trans_z !== e.avg_trans_z) begin
               $error("avg_trans_z exp %0d got %0d", e.avg_trans_z, rsp_data.avg_trans_z);
               fail_count++;
            end
            if (rsp_data.avg_quat_w !== e.avg_quat_w) begin
               $error("avg_quat_w exp %0d got %0d", e.avg_quat_w, rsp_data.avg_quat_w);
               fail_count++;
            end
            if (rsp_data.avg_quat_x !== e.avg_quat_x) begin
               $error("avg_quat_x exp %0d got %0d", e.avg_quat_x, rsp_data.avg_quat_x);
               fail_count++;
            end
            if (rsp_data.avg_quat_y !== e.avg_quat_y) begin
               $error("avg_quat_y exp %0d got %0d", e.avg_quat_y, rsp_data.avg_quat_y);
               fail_count++;
            end
            if (rsp_data.avg_quat_z !== e.avg_quat_z) begin
               $error("avg_quat_z exp %0d got %0d", e.avg_quat_z, rsp_data.avg_quat_z);
               fail_count++;
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off, no stalls in the tail.
   initial begin
      int gap;
      logic held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long && !held) begin
            rsp_ready <= 1'b0;
            repeat (4000) @(posedge clock);
            held = 1'b1;
         end
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Hold one frame on the request side until it transfers.
   task automatic send_frame(req_type f);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frame(f);
   endtask

   function automatic req_type random_frame(int constrained_pct, int last_pct);
      req_type f;
      int pick;
      f.trans_x = $urandom; f.trans_y = $urandom; f.trans_z = $urandom;
      f.quat_w = 16'($urandom); f.quat_x = 16'($urandom);
      f.quat_y = 16'($urandom); f.quat_z = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         // small translations keep averages away from the clamp
         f.trans_x = $signed(f.trans_x) >>> 12;
         f.trans_y = $signed(f.trans_y) >>> 12;
         f.trans_z = $signed(f.trans_z) >>> 12;
      end
      if ($urandom_range(0, 99) < constrained_pct) begin
         case ($urandom_range(0, 3))
            0: f.constraint_value = 17'd0;
            1: f.constraint_value = 17'd65535;
            default: f.constraint_value = 17'($urandom_range(0, 65535));
         endcase
      end else begin
         f.constraint_value = ($urandom_range(0, 1) == 0) ? ONE_Q16
            : 17'($urandom_range(65536, 131071));
      end
      f.last_frame = $urandom_range(0, 99) < last_pct;
      return f;
   endfunction

   typedef struct {
      req_type frame;
      logic    has_fixed;
      rsp_type fixed;
   } stim_row;

   stim_row directed [$];

   function automatic req_type mk(logic [16:0] cv, int tx, int ty, int tz,
                                  int qw, int qx, int qy, int qz, logic lf);
      req_type f;
      f.constraint_value = cv;
      f.trans_x = tx; f.trans_y = ty; f.trans_z = tz;
      f.quat_w = 16'(qw); f.quat_x = 16'(qx); f.quat_y = 16'(qy); f.quat_z = 16'(qz);
      f.last_frame = lf;
      return f;
   endfunction

   function automatic void row(req_type f, logic has, rsp_type r);
      stim_row s;
      s.frame = f; s.has_fixed = has; s.fixed = r;
      directed = {directed, s};
   endfunction

   initial begin
      rsp_type none;
      rsp_type fx;
      int sent;
      none = '0;
      run_is_open = 1'b0;
      frame_idx = '0;
      first_frame = '0;
      clear_sums();

      // Directed table. Fixed rows: single-frame run (first quaternion negated).
      fx = '{start_frame: 16'd0, end_frame: 16'd0, avg_trans_x: 32'sd100,
             avg_trans_y: -32'sd5, avg_trans_z: 32'sd0, avg_quat_w: -16'sd32768,
             avg_quat_x: 16'sd0, avg_quat_y: 16'sd0, avg_quat_z: 16'sd0};
      row(mk(17'd0, 100, -5, 0, 32767, 0, 0, 0, 1'b1), 1'b1, fx);
      // unconstrained frames with no run open: nothing
      row(mk(ONE_Q16, 1, 2, 3, 4, 5, 6, 7, 1'b0), 1'b0, none);
      row(mk(17'h1FFFF, -1, -1, -1, -1, -1, -1, -1, 1'b0), 1'b0, none);
      // zero quaternion gives zero length
      row(mk(17'd65535, 7, 7, 7, 0, 0, 0, 0, 1'b0), 1'b0, none);
      fx = '{start_frame: 16'd2, end_frame: 16'd2, avg_trans_x: 32'sd7,
             avg_trans_y: 32'sd7, avg_trans_z: 32'sd7, avg_quat_w: 16'sd0,
             avg_quat_x: 16'sd0, avg_quat_y: 16'sd0, avg_quat_z: 16'sd0};
      row(mk(ONE_Q16, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, fx);
      // extremes of translation and quaternion, closed by last frame
      row(mk(17'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, -32768, 32767, -32768,
             32767, 1'b0), 1'b0, none);
      row(mk(17'd0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32767, -32768, 32767,
             -32768, 1'b0), 1'b0, none);
      row(mk(17'd1, 32'h80000000, 32'h7fffffff, 0, -32768, -32768, -32768, -32768, 1'b1),
          1'b0, none);
      // unconstrained last frame with no run open
      row(mk(ONE_Q16, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, none);
      // opposite quaternions alternate sign choice
      row(mk(17'd30000, 1000, 2000, 3000, 20000, 1000, -1000, 500, 1'b0), 1'b0, none);
      row(mk(17'd100, -1000, 2000, -3000, -20000, -1000, 1000, -500, 1'b0), 1'b0, none);
      row(mk(17'd65535, 5, 5, 5, 100, 200, 300, 400, 1'b0), 1'b0, none);
      row(mk(17'd99999, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, none);
      // constrained frame opens a run, then an unconstrained last frame with value above one closes it
      row(mk(17'd12345, -77, 77, -77, 0, 0, 32767, 0, 1'b0), 1'b0, none);
      row(mk(17'h1FFFF, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, none);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         int before_n;
         before_n = averages_due.size();
         send_frame(directed[i].frame);
         if (directed[i].has_fixed) begin
            if (averages_due.size() != before_n + 1 || averages_due[$] !== directed[i].fixed)
            begin
               $error("directed row %0d: predicted %p typed %p", i,
                      averages_due.size() > before_n ? averages_due[$] : none,
                      directed[i].fixed);
               fail_count++;
            end
         end
      end

      // Random part: mostly runs of constrained frames with random content.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == 300) hold_long = 1'b1;
         if (sent >= RANDOM_ITEMS - 100) quiet_tail = 1'b1;
         if ($urandom_range(0, 4) != 0) send_frame(random_frame(85, 4));
         else send_frame(random_frame(30, 15));
         sent++;
      end
      // close any run still open
      send_frame(mk(ONE_Q16, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      req_valid <= 1'b0;

      while (averages_due.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("Covered %0d directed and %0d random frames, %0d runs closed.",
               directed.size(), sent + 1, runs_closed);
      if (fail_count == 0 && averages_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/crav_pkg.sv
design/crav_div.sv
design/crav_sqrt.sv
design/constraint_run_averager_top.sv
verif/tb_constraint_run_averager_top.sv
